FILE: rtl/els_pkg.sv
// Shared types and constants for the e-stop link supervisor.
// Holds the input/result beat structs, event codes and register indexes.
// No dependencies.
`default_nettype none

package els_pkg;

    localparam int unsigned CounterWidth = 32;
    localparam int unsigned RunWidth     = 8;
    localparam int unsigned TickWidth    = 24;
    localparam int unsigned CfgIdxWidth  = 2;
    localparam int unsigned CfgDataWidth = 24;

    // Item kinds
    localparam logic FUNC_PACKET = 1'b0;
    localparam logic FUNC_TICK   = 1'b1;

    // Result event codes
    localparam logic [1:0] EV_TICK    = 2'd0;
    localparam logic [1:0] EV_GOOD    = 2'd1;
    localparam logic [1:0] EV_BAD     = 2'd2;
    localparam logic [1:0] EV_TIMEOUT = 2'd3;

    // Register indexes
    localparam logic [CfgIdxWidth-1:0] CFG_MAX_LOST     = 2'd0;
    localparam logic [CfgIdxWidth-1:0] CFG_RELEASE_THR  = 2'd1;
    localparam logic [CfgIdxWidth-1:0] CFG_TIMEOUT_TICK = 2'd2;

    // Register reset values
    localparam logic [RunWidth-1:0]  MAX_LOST_RST     = 8'd3;
    localparam logic [RunWidth-1:0]  RELEASE_THR_RST  = 8'd3;
    localparam logic [TickWidth-1:0] TIMEOUT_TICK_RST = 24'd100000;

    localparam logic [RunWidth-1:0] RUN_MAX = {RunWidth{1'b1}};

    typedef struct packed {
        logic                    func;
        logic [CounterWidth-1:0] rx_counter;
    } in_item_t;

    typedef struct packed {
        logic       stop_active;
        logic       watchdog_pulse;
        logic [1:0] event_code;
    } out_item_t;

endpackage

`default_nettype wire

FILE: rtl/estop_link_supervisor.sv
// E-stop link supervisor: two-register pipeline with counter checks between.
// Depends on els_pkg for beat structs, event codes and register indexes.
`default_nettype none

// Usage
//   in channel  (in_valid/in_stall/in_data): one beat is either a received
//     packet carrying its decoded rolling counter, or one timer tick.
//   out channel (out_valid/out_stall/out_data): exactly one result beat per
//     input beat, in order: stop state after the item, release pulse, event.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): always ready;
//     index 0 max_lost, 1 release_threshold, 2 timeout_ticks, 3 ignored.
//     Write only while no beat is in flight.
// Path: an accepted beat is taken into the input register; its result is
//   computed from it, registered in the output register and offered from then on.
// Throughput: one beat per cycle while results are not stalled; the state
//   update is a 32-bit subtract, a compare and two 8-bit/24-bit counter steps.
// Reset: stop asserted, counters and last counter cleared, registers at
//   max_lost 3, release_threshold 3, timeout_ticks 100000; no beats held.
// Stall: a stalled result holds in the output register while the input
//   register still takes one more beat; in_stall rises only when both are
//   full and the result is not taken.
module estop_link_supervisor (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  in_valid,
    output logic                                 in_stall,
    input  wire  els_pkg::in_item_t              in_data,
    output logic                                 out_valid,
    input  wire                                  out_stall,
    output els_pkg::out_item_t                   out_data,
    input  wire                                  cfg_valid,
    output logic                                 cfg_ready,
    input  wire  [els_pkg::CfgIdxWidth-1:0]      cfg_index,
    input  wire  [els_pkg::CfgDataWidth-1:0]     cfg_data
);

    // Configuration
    logic [els_pkg::RunWidth-1:0]     max_lost_reg;
    logic [els_pkg::RunWidth-1:0]     release_thr_reg;
    logic [els_pkg::TickWidth-1:0]    timeout_tick_reg;

    // Supervisor state
    logic                             stop_reg,     stop_next;
    logic [els_pkg::CounterWidth-1:0] last_reg,     last_next;
    logic [els_pkg::RunWidth-1:0]     good_run_reg, good_run_next;
    logic [els_pkg::RunWidth-1:0]     bad_run_reg,  bad_run_next;
    logic [els_pkg::TickWidth-1:0]    tick_reg,     tick_next;

    // Pipeline
    logic                             in_valid_reg;
    els_pkg::in_item_t                in_data_reg;
    logic                             out_valid_reg;
    els_pkg::out_item_t               out_data_reg;
    els_pkg::out_item_t               out_data_next;

    logic                             out_free;
    logic                             process;
    logic                             in_take;

    logic [els_pkg::CounterWidth-1:0] step;
    logic                             good;
    logic [els_pkg::TickWidth-1:0]    tick_inc;
    logic [els_pkg::RunWidth-1:0]     run_tmp;
    logic                             pulse;
    logic [1:0]                       ev_next;

    assign out_free  = !out_valid_reg || !out_stall;
    assign process   = in_valid_reg && out_free;
    assign in_stall  = in_valid_reg && !out_free;
    assign in_take   = in_valid && !in_stall;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign step     = in_data_reg.rx_counter - last_reg;
    assign good     = (step != '0)
                   && (step <= {{(els_pkg::CounterWidth-els_pkg::RunWidth){1'b0}}, max_lost_reg});
    assign tick_inc = tick_reg + 1'b1;

    always_comb
    begin
        stop_next     = stop_reg;
        last_next     = last_reg;
        good_run_next = good_run_reg;
        bad_run_next  = bad_run_reg;
        tick_next     = tick_reg;
        pulse         = 1'b0;
        ev_next       = els_pkg::EV_TICK;
        run_tmp       = '0;

        if (in_data_reg.func == els_pkg::FUNC_PACKET) begin
            ev_next = good ? els_pkg::EV_GOOD : els_pkg::EV_BAD;
            if (stop_reg) begin
                if (good) begin
                    run_tmp   = (good_run_reg == els_pkg::RUN_MAX) ? good_run_reg
                                                                   : good_run_reg + 1'b1;
                    tick_next = '0;
                end
                last_next = in_data_reg.rx_counter;
                // Release once the good run reaches the threshold
                if (run_tmp >= release_thr_reg) begin
                    stop_next     = 1'b0;
                    good_run_next = '0;
                    pulse         = 1'b1;
                end else begin
                    good_run_next = run_tmp;
                end
            end else begin
                if (good) begin
                    last_next    = in_data_reg.rx_counter;
                    bad_run_next = '0;
                    tick_next    = '0;
                end else begin
                    run_tmp = (bad_run_reg == els_pkg::RUN_MAX) ? bad_run_reg
                                                               : bad_run_reg + 1'b1;
                    if (run_tmp >= max_lost_reg) begin
                        stop_next    = 1'b1;
                        bad_run_next = '0;
                    end else begin
                        bad_run_next = run_tmp;
                    end
                end
            end
        end else begin
            // Wrap of the 24-bit tick count also counts as a timeout
            if ((tick_inc >= timeout_tick_reg) || (tick_inc == '0)) begin
                stop_next     = 1'b1;
                good_run_next = '0;
                tick_next     = '0;
                ev_next       = els_pkg::EV_TIMEOUT;
            end else begin
                tick_next = tick_inc;
            end
        end

        out_data_next.stop_active    = stop_next;
        out_data_next.watchdog_pulse = pulse;
        out_data_next.event_code     = ev_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            max_lost_reg     <= els_pkg::MAX_LOST_RST;
            release_thr_reg  <= els_pkg::RELEASE_THR_RST;
            timeout_tick_reg <= els_pkg::TIMEOUT_TICK_RST;
            stop_reg         <= 1'b1;
            last_reg         <= '0;
            good_run_reg     <= '0;
            bad_run_reg      <= '0;
            tick_reg         <= '0;
            in_valid_reg     <= 1'b0;
            out_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    els_pkg::CFG_MAX_LOST:
                        max_lost_reg <= cfg_data[els_pkg::RunWidth-1:0];
                    els_pkg::CFG_RELEASE_THR:
                        release_thr_reg <= cfg_data[els_pkg::RunWidth-1:0];
                    els_pkg::CFG_TIMEOUT_TICK:
                        timeout_tick_reg <= cfg_data[els_pkg::TickWidth-1:0];
                    default: ;
                endcase
            end

            if (process) begin
                stop_reg     <= stop_next;
                last_reg     <= last_next;
                good_run_reg <= good_run_next;
                bad_run_reg  <= bad_run_next;
                tick_reg     <= tick_next;
            end

            if (in_take) begin
                in_valid_reg <= 1'b1;
            end else if (process) begin
                in_valid_reg <= 1'b0;
            end

            if (process) begin
                out_valid_reg <= 1'b1;
            end else if (out_free) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_take) begin
            in_data_reg <= in_data;
        end
        if (process) begin
            out_data_reg <= out_data_next;
        end
    end

    a_pulse_means_released: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.watchdog_pulse |-> !out_data_reg.stop_active)
        else $error("release pulse with stop still asserted");

    a_timeout_means_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_data_reg.event_code == els_pkg::EV_TIMEOUT)
        |-> out_data_reg.stop_active)
        else $error("timeout result without stop");

    // A zero release threshold lets a bad packet release as well
    a_release_on_packet: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(stop_reg)
        |-> $past(process && (in_data_reg.func == els_pkg::FUNC_PACKET)))
        else $error("stop cleared without a packet");

    a_result_follows_process: assert property (@(posedge clk) disable iff (!rst_n)
        process |=> out_valid_reg)
        else $error("processed item produced no result");

    a_no_input_while_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !process |=> in_valid_reg && $stable(in_data_reg))
        else $error("held input beat lost or overwritten");

endmodule

`default_nettype wire
